// ===== hdl/pat_pkg.sv =====
// Shared definitions for the positional array table.
// Request kinds, status codes and fixed field widths; used by positional_array_table_top.
package pat_pkg;

	// Fixed port field widths
	localparam int KIND_W   = 3;
	localparam int POS_W    = 6;
	localparam int ITEM_W   = 32;
	localparam int RDVAL_W  = 32;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 7;

	// Request kinds
	localparam logic [KIND_W-1:0] KIND_READ      = 3'd0;
	localparam logic [KIND_W-1:0] KIND_OVERWRITE = 3'd1;
	localparam logic [KIND_W-1:0] KIND_APPEND    = 3'd2;
	localparam logic [KIND_W-1:0] KIND_REMOVE    = 3'd3;
	localparam logic [KIND_W-1:0] KIND_INSERT    = 3'd4;
	localparam logic [KIND_W-1:0] KIND_DELETE    = 3'd5;

	// Status codes
	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

endpackage

// ===== hdl/pat_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies; contents are undefined until written.
module pat_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== hdl/positional_array_table_top.sv =====
// Top level of the positional array table: request decode, shift sequencer and result register.
// Depends on pat_pkg and pat_ram.
//
//  channel | signals                                    | direction
//  --------+--------------------------------------------+----------
//  request | in_valid, in_ready, kind, position, item_value | in
//  result  | out_valid, out_ready, read_value, status, entry_count | out
//
// Overwrite, append, errors and unused kinds go from the request beat straight to S_DONE.
// Read and remove-last pass through S_RDWAIT to take the registered RAM read data.
// Insert shifts (count - position) entries, then writes the value in S_INSWR; delete shifts
// (count - position - 1) entries: the single RAM read and write ports move one entry per cycle.
// Reset clears the count and the control state; entry storage is not cleared.
// A new request beat is taken once the previous result sits in the output register.
module positional_array_table_top #(
	parameter int CAPACITY    = 64,
	parameter int VALUE_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [pat_pkg::KIND_W-1:0]    kind,
	input  logic [pat_pkg::POS_W-1:0]     position,
	input  logic [pat_pkg::ITEM_W-1:0]    item_value,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [pat_pkg::RDVAL_W-1:0]   read_value,
	output logic [pat_pkg::STATUS_W-1:0]  status,
	output logic [pat_pkg::COUNT_W-1:0]   entry_count
);

	localparam int AW    = $clog2(CAPACITY);
	localparam int CW    = $clog2(CAPACITY + 1);
	localparam int CMPW  = ((CW > pat_pkg::POS_W) ? CW : pat_pkg::POS_W) + 1;
	localparam int EXTW  = (VALUE_WIDTH > pat_pkg::ITEM_W) ? VALUE_WIDTH : pat_pkg::ITEM_W;
	localparam int OEXTW = (VALUE_WIDTH > pat_pkg::RDVAL_W) ? VALUE_WIDTH : pat_pkg::RDVAL_W;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RDWAIT,
		S_SHIFT,
		S_INSWR,
		S_DONE
	} state_t;

	state_t state_q;
	state_t acc_next;

	logic [CW-1:0]                  count_q;
	logic [CW-1:0]                  acc_count;
	logic [pat_pkg::STATUS_W-1:0]   acc_status;
	logic                           acc_write;
	logic [AW-1:0]                  acc_waddr;

	logic [pat_pkg::STATUS_W-1:0]   res_status_q;
	logic [pat_pkg::RDVAL_W-1:0]    res_value_q;

	logic                           out_valid_q;
	logic [pat_pkg::RDVAL_W-1:0]    out_value_q;
	logic [pat_pkg::STATUS_W-1:0]   out_status_q;
	logic [pat_pkg::COUNT_W-1:0]    out_count_q;

	logic                           pend_s1;
	logic [AW-1:0]                  wr_addr_s1;
	logic [AW-1:0]                  rd_addr_q;
	logic [CW-1:0]                  remain_q;
	logic                           is_ins_q;
	logic [AW-1:0]                  pos_q;
	logic [VALUE_WIDTH-1:0]         val_q;

	logic                           in_fire;
	logic                           out_free;
	logic                           shift_issue;
	logic [CMPW-1:0]                n_x;
	logic [CMPW-1:0]                p_x;
	logic                           pos_lt;
	logic                           pos_le;
	logic                           full;
	logic                           empty;
	logic [EXTW-1:0]                item_ext;
	logic [VALUE_WIDTH-1:0]         item_val;
	logic [OEXTW-1:0]               rdata_ext;
	logic [CMPW-1:0]                ins_remain;
	logic [CMPW-1:0]                del_remain;
	logic [CMPW-1:0]                del_start;

	logic                           ram_we;
	logic [AW-1:0]                  ram_waddr;
	logic [VALUE_WIDTH-1:0]         ram_wdata;
	logic [AW-1:0]                  ram_raddr;
	logic [VALUE_WIDTH-1:0]         ram_rdata;

	assign in_ready    = (state_q == S_IDLE);
	assign in_fire     = in_valid && in_ready;
	assign out_free    = !out_valid_q || out_ready;
	assign shift_issue = (remain_q != '0);

	assign out_valid   = out_valid_q;
	assign read_value  = out_value_q;
	assign status      = out_status_q;
	assign entry_count = out_count_q;

	// Value width conversion in both directions.
	assign item_ext  = EXTW'(item_value);
	assign item_val  = item_ext[VALUE_WIDTH-1:0];
	assign rdata_ext = OEXTW'(ram_rdata);

	// Position checks against the live count.
	assign n_x    = CMPW'(count_q);
	assign p_x    = CMPW'(position);
	assign pos_lt = (p_x < n_x);
	assign pos_le = (p_x <= n_x);
	assign full   = (n_x == CMPW'(CAPACITY));
	assign empty  = (count_q == '0);

	assign ins_remain = n_x - p_x;
	assign del_remain = n_x - p_x - CMPW'(1);
	assign del_start  = p_x + CMPW'(1);

	// Request decode: status, count update, direct write and next state.
	always_comb begin
		acc_status = pat_pkg::ST_OK;
		acc_count  = count_q;
		acc_write  = 1'b0;
		acc_waddr  = AW'(position);
		acc_next   = S_DONE;
		case (kind)
			pat_pkg::KIND_READ: begin
				if (!pos_lt) begin
					acc_status = pat_pkg::ST_RANGE;
				end else begin
					acc_next = S_RDWAIT;
				end
			end
			pat_pkg::KIND_OVERWRITE: begin
				if (!pos_lt) begin
					acc_status = pat_pkg::ST_RANGE;
				end else begin
					acc_write = 1'b1;
				end
			end
			pat_pkg::KIND_APPEND: begin
				if (full) begin
					acc_status = pat_pkg::ST_FULL;
				end else begin
					acc_write = 1'b1;
					acc_waddr = AW'(count_q);
					acc_count = count_q + CW'(1);
				end
			end
			pat_pkg::KIND_REMOVE: begin
				if (empty) begin
					acc_status = pat_pkg::ST_EMPTY;
				end else begin
					acc_count = count_q - CW'(1);
					acc_next  = S_RDWAIT;
				end
			end
			pat_pkg::KIND_INSERT: begin
				if (!pos_le) begin
					acc_status = pat_pkg::ST_RANGE;
				end else if (full) begin
					acc_status = pat_pkg::ST_FULL;
				end else begin
					acc_count = count_q + CW'(1);
					acc_next  = S_SHIFT;
				end
			end
			pat_pkg::KIND_DELETE: begin
				if (!pos_lt) begin
					acc_status = pat_pkg::ST_RANGE;
				end else begin
					acc_count = count_q - CW'(1);
					acc_next  = S_SHIFT;
				end
			end
			default: begin
				acc_status = pat_pkg::ST_OK;
			end
		endcase
	end

	// RAM read address: request position or last entry while idle, sequencer pointer otherwise.
	always_comb begin
		if (state_q == S_IDLE) begin
			if (kind == pat_pkg::KIND_REMOVE) begin
				ram_raddr = AW'(count_q - CW'(1));
			end else begin
				ram_raddr = AW'(position);
			end
		end else begin
			ram_raddr = rd_addr_q;
		end
	end

	// RAM write port: direct writes, shifted entries, and the inserted value.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = pos_q;
		ram_wdata = val_q;
		case (state_q)
			S_IDLE: begin
				ram_we    = in_fire && acc_write;
				ram_waddr = acc_waddr;
				ram_wdata = item_val;
			end
			S_SHIFT: begin
				ram_we    = pend_s1;
				ram_waddr = wr_addr_s1;
				ram_wdata = ram_rdata;
			end
			S_INSWR: begin
				ram_we = 1'b1;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	// State, count, shift control and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			pend_s1      <= 1'b0;
			remain_q     <= '0;
			res_status_q <= pat_pkg::ST_OK;
			res_value_q  <= '0;
			out_valid_q  <= 1'b0;
			out_value_q  <= '0;
			out_status_q <= pat_pkg::ST_OK;
			out_count_q  <= '0;
		end else begin
			if (out_valid_q && out_ready && (state_q != S_DONE)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					pend_s1 <= 1'b0;
					if (in_fire) begin
						state_q      <= acc_next;
						count_q      <= acc_count;
						res_status_q <= acc_status;
						res_value_q  <= '0;
						if (kind == pat_pkg::KIND_INSERT) begin
							remain_q <= CW'(ins_remain);
						end else begin
							remain_q <= CW'(del_remain);
						end
					end
				end
				S_RDWAIT: begin
					res_value_q <= rdata_ext[pat_pkg::RDVAL_W-1:0];
					state_q     <= S_DONE;
				end
				S_SHIFT: begin
					pend_s1 <= shift_issue;
					if (shift_issue) begin
						remain_q <= remain_q - CW'(1);
					end else begin
						state_q <= is_ins_q ? S_INSWR : S_DONE;
					end
				end
				S_INSWR: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						out_value_q  <= res_value_q;
						out_status_q <= res_status_q;
						out_count_q  <= pat_pkg::COUNT_W'(count_q);
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Shift pointers and the latched request; reads walk one way, writes trail by one entry.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			pos_q    <= AW'(position);
			val_q    <= item_val;
			is_ins_q <= (kind == pat_pkg::KIND_INSERT);
			if (kind == pat_pkg::KIND_INSERT) begin
				rd_addr_q <= AW'(count_q - CW'(1));
			end else begin
				rd_addr_q <= AW'(del_start);
			end
		end else if (state_q == S_SHIFT && shift_issue) begin
			if (is_ins_q) begin
				rd_addr_q  <= rd_addr_q - AW'(1);
				wr_addr_s1 <= rd_addr_q + AW'(1);
			end else begin
				rd_addr_q  <= rd_addr_q + AW'(1);
				wr_addr_s1 <= rd_addr_q - AW'(1);
			end
		end
	end

	pat_ram #(
		.WIDTH(VALUE_WIDTH),
		.DEPTH(CAPACITY)
	) u_entries (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

`ifndef ASSERT_OFF
	// The live count never exceeds the capacity.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		CMPW'(count_q) <= CMPW'(CAPACITY))
		else $error("live count above capacity");

	// A request that fails leaves the count unchanged.
	a_err_keeps_count: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && (acc_status != pat_pkg::ST_OK) |=> count_q == $past(count_q))
		else $error("failing request changed the count");

	// While shifting, the entry written is never the entry being read.
	a_shift_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SHIFT) && pend_s1 && shift_issue |-> ram_waddr != ram_raddr)
		else $error("shift write hits the entry being read");

	// A result waiting in the output register is never replaced.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |=> out_valid_q && $stable(out_count_q))
		else $error("pending result overwritten");
`endif

endmodule
